// ===== hdl/lbr_pkg.sv =====
// shared constants for the lamp brightness regulator
package lbr_pkg;

	localparam int DUTY_WIDTH_DEF = 13;
	localparam int SAMPLE_W       = 10;
	localparam int BAND_W         = 8;
	localparam int STEPS_W        = 10;
	localparam int WAIT_W         = 6;
	localparam int PRESS_W        = 2;
	localparam int PASS_W         = 4;
	localparam int SWEEP_W        = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;

	localparam int FLOOR_RST      = 1618;
	localparam int CEILING_RST    = 8096;
	localparam int TARGET_RST     = 5633;
	localparam int RSETPOINT_RST  = 0;
	localparam int RDUTY_RST      = 0;
	localparam int BAND_RST       = 15;
	localparam int STEPS_RST      = 62;

	localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_TARGET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESTORED_SP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RESTORED_DUTY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 3'd6;

	localparam logic [WAIT_W-1:0] START_WAIT   = 6'd5;
	localparam logic [WAIT_W-1:0] WAIT_BAND1   = 6'd39;
	localparam logic [WAIT_W-1:0] WAIT_BAND2   = 6'd29;
	localparam logic [WAIT_W-1:0] WAIT_BAND3   = 6'd19;
	localparam logic [WAIT_W-1:0] WAIT_FAR     = 6'd9;
	localparam logic [WAIT_W-1:0] WAIT_EQUAL   = 6'd49;

	localparam logic [SWEEP_W-1:0] SWEEP_DIV   = 3'd6;
	localparam logic [PASS_W-1:0]  PASS_LIMIT  = 4'd10;
	localparam logic [PRESS_W-1:0] PRESS_MAX   = 2'd3;
	localparam logic [PRESS_W-1:0] PRESS_DOUBLE = 2'd2;

endpackage

// ===== hdl/lbr_cfg.sv =====
// configuration register file of the lamp brightness regulator
module lbr_cfg #(
	parameter int DW = lbr_pkg::DUTY_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [lbr_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [lbr_pkg::CFG_DATA_W-1:0]      wr_data,
	output logic [DW-1:0]                       duty_floor,
	output logic [DW-1:0]                       duty_ceiling,
	output logic [DW-1:0]                       default_target,
	output logic [lbr_pkg::SAMPLE_W-1:0]        restored_setpoint,
	output logic [DW-1:0]                       restored_duty,
	output logic [lbr_pkg::BAND_W-1:0]          band_width,
	output logic [lbr_pkg::STEPS_W-1:0]         long_press_steps
);

	logic [DW-1:0]                floor_q, ceiling_q, target_q, rduty_q;
	logic [lbr_pkg::SAMPLE_W-1:0] rsp_q;
	logic [lbr_pkg::BAND_W-1:0]   band_q;
	logic [lbr_pkg::STEPS_W-1:0]  steps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= DW'(lbr_pkg::FLOOR_RST);
			ceiling_q <= DW'(lbr_pkg::CEILING_RST);
			target_q  <= DW'(lbr_pkg::TARGET_RST);
			rsp_q     <= lbr_pkg::SAMPLE_W'(lbr_pkg::RSETPOINT_RST);
			rduty_q   <= DW'(lbr_pkg::RDUTY_RST);
			band_q    <= lbr_pkg::BAND_W'(lbr_pkg::BAND_RST);
			steps_q   <= lbr_pkg::STEPS_W'(lbr_pkg::STEPS_RST);
		end else if (wr_en) begin
			unique case (wr_index)
				lbr_pkg::REG_DUTY_FLOOR:     floor_q   <= wr_data[DW-1:0];
				lbr_pkg::REG_DUTY_CEILING:   ceiling_q <= wr_data[DW-1:0];
				lbr_pkg::REG_DEFAULT_TARGET: target_q  <= wr_data[DW-1:0];
				lbr_pkg::REG_RESTORED_SP:    rsp_q     <= wr_data[lbr_pkg::SAMPLE_W-1:0];
				lbr_pkg::REG_RESTORED_DUTY:  rduty_q   <= wr_data[DW-1:0];
				lbr_pkg::REG_BAND_WIDTH:     band_q    <= wr_data[lbr_pkg::BAND_W-1:0];
				lbr_pkg::REG_LONG_PRESS:     steps_q   <= wr_data[lbr_pkg::STEPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign duty_floor        = floor_q;
	assign duty_ceiling      = ceiling_q;
	assign default_target    = target_q;
	assign restored_setpoint = rsp_q;
	assign restored_duty     = rduty_q;
	assign band_width        = band_q;
	assign long_press_steps  = steps_q;

endmodule

// ===== hdl/lamp_brightness_regulator_top.sv =====
// top level of the lamp brightness regulator: tick register, mode logic, result register
//
// Each input word is one timer tick carrying a light sensor sample and the
// calibration button level; each tick yields exactly one result word with
// the duty to drive, a store request pulse and the values to store.
// Input channel: in_valid / in_stall with sensor_sample and button_down.
// Output channel: out_valid / out_stall with duty, store_request,
// stored_setpoint and stored_duty.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index, cfg_data;
// write only while no tick is in flight.
// An accepted word passes through the tick register and then the result register to out_valid.
// Throughput: one word per cycle while out_stall holds no pending result; the tick
// register feeds one pass of mode and regulation logic into the result register.
// Reset clears mode, counters and valid flags; config registers return to
// their defaults and the block starts with its five tick start wait.
// While out_stall holds a pending result, the tick register keeps one more
// word and then in_stall rises until the result is taken.
module lamp_brightness_regulator_top #(
	parameter int DUTY_WIDTH = lbr_pkg::DUTY_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lbr_pkg::SAMPLE_W-1:0]      sensor_sample,
	input  logic                              button_down,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [DUTY_WIDTH-1:0]             duty,
	output logic                              store_request,
	output logic [lbr_pkg::SAMPLE_W-1:0]      stored_setpoint,
	output logic [DUTY_WIDTH-1:0]             stored_duty,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lbr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int DW  = DUTY_WIDTH;
	localparam int SW  = ((DW > lbr_pkg::STEPS_W) ? DW : lbr_pkg::STEPS_W) + 1;
	localparam int SPW = lbr_pkg::SAMPLE_W;

	typedef enum logic [2:0] {
		M_START = 3'd0,
		M_RAMP  = 3'd1,
		M_REG   = 3'd2,
		M_CAL   = 3'd3,
		M_MAX   = 3'd4
	} mode_t;

	logic [DW-1:0]                duty_floor, duty_ceiling, default_target, restored_duty;
	logic [SPW-1:0]               restored_setpoint;
	logic [lbr_pkg::BAND_W-1:0]   band_width;
	logic [lbr_pkg::STEPS_W-1:0]  long_press_steps;

	lbr_cfg #(.DW(DW)) u_cfg (
		.clk               (clk),
		.arst_n            (arst_n),
		.wr_en             (cfg_valid),
		.wr_index          (cfg_index),
		.wr_data           (cfg_data),
		.duty_floor        (duty_floor),
		.duty_ceiling      (duty_ceiling),
		.default_target    (default_target),
		.restored_setpoint (restored_setpoint),
		.restored_duty     (restored_duty),
		.band_width        (band_width),
		.long_press_steps  (long_press_steps)
	);

	assign cfg_ready = 1'b1;

	// tick register
	logic           valid_s1;
	logic [SPW-1:0] sample_s1;
	logic           button_s1;
	logic           advance;

	// state
	mode_t                        mode_q;
	logic [DW-1:0]                duty_q, calib_q;
	logic [lbr_pkg::WAIT_W-1:0]   wait_q;
	logic [SPW-1:0]               setpoint_q, last_sp_q;
	logic [lbr_pkg::PRESS_W-1:0]  press_q;
	logic [lbr_pkg::PASS_W-1:0]   pass_q;
	logic [lbr_pkg::SWEEP_W-1:0]  sweep_q;
	logic                         out_valid_q, store_q;

	// next state
	mode_t                        nx_mode;
	logic [DW-1:0]                nx_duty, nx_calib, target;
	logic [DW:0]                  duty_inc;
	logic [SW-1:0]                press_limit;
	logic [lbr_pkg::WAIT_W-1:0]   nx_wait;
	logic [SPW-1:0]               nx_sp, nx_last, err;
	logic [lbr_pkg::PRESS_W-1:0]  nx_press;
	logic [lbr_pkg::PASS_W-1:0]   nx_pass;
	logic [lbr_pkg::SWEEP_W-1:0]  nx_sweep;
	logic                         nx_store, do_tick, do_pass;
	logic [SPW:0]                 band1, band2, band3;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			sample_s1 <= sensor_sample;
			button_s1 <= button_down;
		end
	end

	assign duty_inc    = {1'b0, duty_q} + {{DW{1'b0}}, 1'b1};
	assign press_limit = SW'(duty_floor) + SW'(long_press_steps);
	assign band1       = (SPW + 1)'(band_width);
	assign band2       = (SPW + 1)'({band_width, 1'b0});
	assign band3       = band1 + band2;

	always_comb begin
		nx_mode  = mode_q;
		nx_duty  = duty_q;
		nx_calib = calib_q;
		nx_wait  = wait_q;
		nx_sp    = setpoint_q;
		nx_last  = last_sp_q;
		nx_press = press_q;
		nx_pass  = pass_q;
		nx_sweep = sweep_q;
		nx_store = 1'b0;
		do_tick  = 1'b0;
		do_pass  = 1'b0;
		err      = '0;
		target   = (calib_q > duty_floor) ? calib_q : default_target;
		if (target > duty_ceiling) begin
			target = duty_ceiling;
		end

		unique case (mode_q)
			M_START: begin
				if (wait_q != '0) begin
					nx_wait = wait_q - 1'b1;
				end
				nx_duty = '0;
				if (nx_wait == '0) begin
					nx_sp    = restored_setpoint;
					nx_last  = restored_setpoint;
					nx_calib = restored_duty;
					nx_mode  = M_RAMP;
				end
			end
			M_RAMP: begin
				if (duty_q < target) begin
					nx_duty = duty_inc[DW-1:0];
				end else begin
					nx_mode = M_REG;
					nx_wait = '0;
					do_tick = 1'b1;
				end
			end
			M_CAL: begin
				if (button_s1) begin
					nx_sweep = sweep_q + 1'b1;
					if (nx_sweep >= lbr_pkg::SWEEP_DIV) begin
						nx_sweep = '0;
						if (SW'(duty_inc) > press_limit) begin
							nx_press = '0;
						end
						nx_duty  = ((DW + 1)'(duty_ceiling) < duty_inc) ? duty_ceiling
						                                                : duty_inc[DW-1:0];
						nx_calib = nx_duty;
						nx_sp    = sample_s1;
					end
				end else if (press_q >= lbr_pkg::PRESS_DOUBLE) begin
					nx_mode = M_MAX;
				end else begin
					nx_mode = M_REG;
					do_pass = 1'b1;
				end
			end
			M_MAX: begin
				if (duty_q < duty_ceiling) begin
					nx_duty = duty_inc[DW-1:0];
				end else begin
					nx_calib = duty_q;
					nx_sp    = sample_s1;
					nx_press = '0;
					nx_mode  = M_REG;
					do_pass  = 1'b1;
				end
			end
			default: begin
				nx_mode = M_REG;
				do_tick = 1'b1;
			end
		endcase

		if (do_tick) begin
			if (nx_wait != '0) begin
				nx_wait = nx_wait - 1'b1;
			end else if (button_s1) begin
				nx_press = (nx_press < lbr_pkg::PRESS_MAX) ? nx_press + 1'b1
				                                           : lbr_pkg::PRESS_MAX;
				nx_duty  = duty_floor;
				nx_pass  = '0;
				nx_sweep = '0;
				nx_mode  = M_CAL;
			end else begin
				do_pass = 1'b1;
			end
		end

		if (do_pass) begin
			if (nx_pass >= lbr_pkg::PASS_LIMIT) begin
				nx_press = '0;
				nx_pass  = '0;
			end
			if (nx_sp != nx_last) begin
				nx_last  = nx_sp;
				nx_store = 1'b1;
			end
			if (sample_s1 > nx_sp) begin
				err = sample_s1 - nx_sp;
				if (nx_duty > duty_floor) begin
					nx_duty = nx_duty - 1'b1;
				end
			end else if (sample_s1 < nx_sp) begin
				err = nx_sp - sample_s1;
				if (nx_duty < duty_ceiling) begin
					nx_duty = nx_duty + 1'b1;
				end
			end
			priority if (err == '0) begin
				nx_wait = lbr_pkg::WAIT_EQUAL;
			end else if ({1'b0, err} <= band1) begin
				nx_wait = lbr_pkg::WAIT_BAND1;
			end else if ({1'b0, err} <= band2) begin
				nx_wait = lbr_pkg::WAIT_BAND2;
			end else if ({1'b0, err} <= band3) begin
				nx_wait = lbr_pkg::WAIT_BAND3;
			end else begin
				nx_wait = lbr_pkg::WAIT_FAR;
			end
			nx_pass = nx_pass + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_START;
			duty_q      <= '0;
			calib_q     <= DW'(lbr_pkg::RDUTY_RST);
			wait_q      <= lbr_pkg::START_WAIT;
			setpoint_q  <= SPW'(lbr_pkg::RSETPOINT_RST);
			last_sp_q   <= SPW'(lbr_pkg::RSETPOINT_RST);
			press_q     <= '0;
			pass_q      <= '0;
			sweep_q     <= '0;
			store_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				mode_q     <= nx_mode;
				duty_q     <= nx_duty;
				calib_q    <= nx_calib;
				wait_q     <= nx_wait;
				setpoint_q <= nx_sp;
				last_sp_q  <= nx_last;
				press_q    <= nx_press;
				pass_q     <= nx_pass;
				sweep_q    <= nx_sweep;
				store_q    <= nx_store;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign duty            = duty_q;
	assign store_request   = store_q;
	assign stored_setpoint = last_sp_q;
	assign stored_duty     = calib_q;

endmodule
